@@ rtl/core/frrm_pkg.sv @@
// Shared types and constants for the frame-rate ratio multiply-divide core.
`default_nettype none
package frrm_pkg;
    localparam logic [63:0] TOP_MASK = 64'hffff_ffff_8000_0000;

    // Operations of the shared divider.
    typedef enum logic [1:0] {
        DIV_GCD = 2'd0,
        DIV_QUO = 2'd1
    } div_op_t;

    // Control between sequencer and divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/frrm_divider.sv @@
// Restoring 64-bit divider, one quotient bit per cycle.
`default_nettype none
module frrm_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire frrm_pkg::div_ctl_t ctl,
    input  wire logic [63:0]        dividend,
    input  wire logic [63:0]        divisor,
    output frrm_pkg::div_sts_t      sts,
    output logic [63:0]             quotient,
    output logic [63:0]             remainder
);
    logic [6:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] dsr_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !ctl.start && (count_reg == 7'd1);
            if (ctl.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= 7'd64;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 7'd1;
                if (count_reg == 7'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

@@ rtl/core/frrm_multiplier.sv @@
// 32x32 multiplier, one 16-bit partial product row per cycle.
`default_nettype none
module frrm_multiplier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic             done,
    output logic [63:0]      product
);
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [63:0] acc_reg;
    logic [47:0] part;

    assign part = a_reg * (step_reg[0] ? b_reg[31:16] : b_reg[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !start && step_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg[0])
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg[0])
                acc_reg <= acc_reg + {part, 16'd0};
            else
                acc_reg <= acc_reg + {16'd0, part};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule
`default_nettype wire

@@ rtl/core/frame_rate_ratio_muldiv_core.sv @@
// Top level: multiply a frame-rate fraction by a ratio and reduce it.
// Latency: data dependent. Two products are formed first; each Euclid step and
// each exact division is one pass of the shared divider. One item at a time:
// s_tready is low while an item is at work.
// Hand the result to the output register once it is free, then take the next
// item. Reset (rst_n, async, active low) returns to idle, no result held.
`default_nettype none
module frame_rate_ratio_muldiv_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rate_num[31:0], rate_den[63:32], mul_factor[95:64], div_factor[127:96]
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // new_num[31:0], new_den[63:32]
    output logic [63:0]       m_tdata,
    // was_scaled
    output logic              m_tuser
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_P, ST_MUL_Q, ST_CHECK, ST_GCD, ST_DIV_P, ST_DIV_Q,
        ST_SHIFT, ST_ROUND, ST_GCD2, ST_DIV2_N, ST_DIV2_D, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] p_reg, q_reg, a_reg, b_reg, g_reg;
    logic [6:0]  u_reg;
    logic        scaled_reg;
    logic        second_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic               mul_start;
    logic               mul_done;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_prod;
    frrm_pkg::div_ctl_t dctl;
    frrm_pkg::div_sts_t dsts;
    logic               div_go;
    logic [63:0]        div_n, div_d, div_q, div_r;
    logic [63:0]        half;
    logic [63:0]        sn, sd;

    frrm_multiplier u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
        .done(mul_done), .product(mul_prod)
    );

    frrm_divider u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(div_n), .divisor(div_d),
        .sts(dsts), .quotient(div_q), .remainder(div_r)
    );

    assign s_tready = (state_reg == ST_IDLE);
    // first product on the accepted beat, second as soon as the first is done
    assign mul_start = (s_tvalid && s_tready) || (state_reg == ST_MUL_P && mul_done);
    assign mul_a = (state_reg == ST_IDLE) ? s_tdata[31:0] : b_reg[31:0];
    assign mul_b = (state_reg == ST_IDLE) ? s_tdata[95:64] : b_reg[63:32];

    // launch a divider pass: next Euclid step, or the next exact divide
    assign div_go = ((state_reg == ST_GCD) && !dsts.busy && !dctl.start && !dsts.done)
                 || (((state_reg == ST_DIV_P) || (state_reg == ST_DIV2_N)) && dsts.done);

    // round-half-up constant; u is at least 1 where used
    assign half = 64'd1 << (u_reg - 7'd1);
    assign sn   = (p_reg + half) >> u_reg;
    assign sd   = (q_reg + half) >> u_reg;

    // feed the divider: Euclid step on (a, b) or exact divide by g
    always_comb
    begin
        div_n = a_reg;
        div_d = b_reg;
        unique case (state_reg) inside
            ST_DIV_P, ST_DIV2_N: begin div_n = p_reg; div_d = g_reg; end
            ST_DIV_Q, ST_DIV2_D: begin div_n = q_reg; div_d = g_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            dctl.start   <= 1'b0;
        end
        else
        begin
            dctl.start <= div_go;
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg) inside
                ST_IDLE:
                    if (s_tvalid)
                    begin
                        // hold den operands until the multiplier frees up
                        b_reg      <= {s_tdata[127:96], s_tdata[63:32]};
                        scaled_reg <= 1'b0;
                        second_reg <= 1'b0;
                        u_reg      <= '0;
                        state_reg  <= ST_MUL_P;
                    end
                ST_MUL_P:
                    if (mul_done)
                    begin
                        p_reg     <= mul_prod;
                        state_reg <= ST_MUL_Q;
                    end
                ST_MUL_Q:
                    if (mul_done)
                    begin
                        q_reg     <= mul_prod;
                        state_reg <= ST_CHECK;
                    end
                ST_CHECK:
                    if (p_reg == 64'd0 && q_reg == 64'd0)
                    begin
                        p_reg     <= 64'd0;
                        q_reg     <= 64'd1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        a_reg     <= p_reg;
                        b_reg     <= q_reg;
                        state_reg <= ST_GCD;
                    end
                ST_GCD:
                    // advance Euclid one remainder per divider pass
                    if (!dsts.busy && !dctl.start)
                    begin
                        if (dsts.done)
                        begin
                            a_reg <= b_reg;
                            b_reg <= div_r;
                        end
                        else if (b_reg == 64'd0)
                        begin
                            g_reg     <= a_reg;
                            state_reg <= second_reg ? ST_DIV2_N : ST_DIV_P;
                        end
                    end
                ST_DIV_P, ST_DIV2_N:
                    if (dsts.done)
                    begin
                        p_reg     <= div_q;
                        state_reg <= (state_reg == ST_DIV_P) ? ST_DIV_Q : ST_DIV2_D;
                    end
                ST_DIV_Q, ST_DIV2_D:
                    if (dsts.done)
                    begin
                        q_reg     <= div_q;
                        state_reg <= (state_reg == ST_DIV_Q) ? ST_SHIFT : ST_OUT;
                    end
                ST_SHIFT:
                    // one bit per cycle until the pair fits in 31 bits
                    if ((((p_reg | q_reg) >> u_reg) & frrm_pkg::TOP_MASK) != 64'd0)
                        u_reg <= u_reg + 7'd1;
                    else if (u_reg == 7'd0)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_ROUND;
                ST_ROUND:
                begin
                    scaled_reg <= 1'b1;
                    if (sn[31:0] == 32'd0 || sd[31:0] == 32'd0)
                    begin
                        p_reg     <= 64'd0;
                        q_reg     <= 64'd1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        p_reg      <= {32'd0, sn[31:0]};
                        q_reg      <= {32'd0, sd[31:0]};
                        a_reg      <= {32'd0, sn[31:0]};
                        b_reg      <= {32'd0, sd[31:0]};
                        second_reg <= 1'b1;
                        state_reg  <= ST_GCD;
                    end
                end
                ST_OUT:
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tdata_reg <= {q_reg[31:0], p_reg[31:0]};
                        m_tuser_reg <= scaled_reg;
                        state_reg   <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the frame-rate ratio multiply-divide core, self-checked.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] div_factor;
        logic [31:0] mul_factor;
        logic [31:0] rate_den;
        logic [31:0] rate_num;
    } rate_req_t;

    typedef struct {
        logic [31:0] new_num;
        logic [31:0] new_den;
        logic        was_scaled;
    } rate_res_t;

    localparam logic [63:0] HIGH_BITS = 64'hffff_ffff_8000_0000;
    localparam int NUM_RANDOM = 1500;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    rate_req_t pending_beats[$];
    rate_res_t expected_ratios[$];
    int        mismatches = 0;
    int        beats_in = 0;
    int        beats_offered = 0;
    int        beats_out = 0;
    int        scaled_seen = 0;
    int        gap_left = 0;
    bit        stim_done = 1'b0;
    bit        hold_sink = 1'b0;

    frame_rate_ratio_muldiv_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] euclid64(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Compute the reduced, possibly rescaled ratio for one request.
    function automatic rate_res_t reduce_ratio(rate_req_t req);
        rate_res_t   res;
        logic [63:0] p, q, g, t, half, sn, sd;
        int          u;
        p = 64'(req.rate_num) * 64'(req.mul_factor);
        q = 64'(req.rate_den) * 64'(req.div_factor);
        res.was_scaled = 1'b0;
        u = 0;
        if (p == 0 && q == 0)
        begin
            res.new_num = 32'd0;
            res.new_den = 32'd1;
        end
        else
        begin
            g = euclid64(p, q);
            p = p / g;
            q = q / g;
            t = p | q;
            while ((t & HIGH_BITS) != 0)
            begin
                t = t >> 1;
                u++;
            end
            if (u != 0)
            begin
                half = 64'd1 << (u - 1);
                sn = 64'(32'((p + half) >> u));
                sd = 64'(32'((q + half) >> u));
                res.was_scaled = 1'b1;
                if (sn == 0 || sd == 0)
                begin
                    res.new_num = 32'd0;
                    res.new_den = 32'd1;
                end
                else
                begin
                    g = euclid64(sn, sd);
                    res.new_num = 32'(sn / g);
                    res.new_den = 32'(sd / g);
                end
            end
            else
            begin
                res.new_num = p[31:0];
                res.new_den = q[31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
        mismatches++;
    endtask

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom_range(1, 16);
            3: return $urandom_range(1, 100000);
            4: return 32'h8000_0000 >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(logic [31:0] a, logic [31:0] b, logic [31:0] m, logic [31:0] d);
        rate_req_t req;
        req.rate_num = a;
        req.rate_den = b;
        req.mul_factor = m;
        req.div_factor = d;
        pending_beats.push_back(req);
    endtask

    initial
    begin
        rate_req_t req;
        // Directed: zeros, extremes, unscaled, deep shift, zero after scaling.
        push_req(0, 0, 0, 0);
        push_req(0, 5, 7, 3);
        push_req(5, 0, 7, 3);
        push_req(5, 3, 7, 0);
        push_req(30000, 1001, 1, 1);
        push_req(25, 1, 2, 1);
        push_req(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_req(32'hffff_ffff, 1, 32'hffff_ffff, 1);
        push_req(1, 32'hffff_ffff, 1, 32'hffff_ffff);
        push_req(32'hffff_ffff, 1, 32'hffff_ffff, 32'hffff_fffe);
        push_req(32'h7fff_ffff, 1, 1, 1);
        push_req(32'h8000_0000, 1, 1, 1);
        push_req(32'h8000_0000, 3, 1, 1);
        push_req(1, 32'hffff_fffb, 1, 32'hffff_fff1);
        push_req(32'hffff_fffb, 2, 32'hffff_fff1, 1);
        push_req(24000, 1001, 32'h1234_5678, 32'h0000_0003);
        push_req(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            req.rate_num = pick_word();
            req.rate_den = pick_word();
            req.mul_factor = pick_word();
            req.div_factor = pick_word();
            pending_beats.push_back(req);
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Driver: once the offered beat is taken, idle for a gap or offer the next one.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beats_in == beats_offered))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                s_tdata <= pending_beats.pop_front();
                s_tvalid <= 1'b1;
                beats_offered++;
                gap_left = gap_len();
            end
            else
            begin
                s_tvalid <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    // Input side: record the expectation for each accepted request beat.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_ratios.push_back(reduce_ratio(rate_req_t'(s_tdata)));
            beats_in++;
        end
    end

    // Long hold-off on the sink, counted in its own process.
    initial
    begin
        wait (beats_in == 40);
        hold_sink = 1'b1;
        repeat (20000) @(posedge clk);
        hold_sink = 1'b0;
    end

    // Sink ready toggles at the falling edge.
    always @(negedge clk)
    begin
        if (hold_sink)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) < 70);
    end

    // Monitor: compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        rate_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (expected_ratios.size() == 0)
                report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
            else
            begin
                want = expected_ratios.pop_front();
                if (m_tdata[31:0] !== want.new_num)
                    report_mismatch("new_num", m_tdata[31:0], want.new_num);
                if (m_tdata[63:32] !== want.new_den)
                    report_mismatch("new_den", m_tdata[63:32], want.new_den);
                if (m_tuser !== want.was_scaled)
                    report_mismatch("was_scaled", 32'(m_tuser), 32'(want.was_scaled));
                if (want.was_scaled) scaled_seen++;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_ratios.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d request beats, %0d result beats, %0d rescaled.",
                 beats_in, beats_out, scaled_seen);
        if (mismatches == 0 && expected_ratios.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog: stops the run and reports failure if it has not finished.
    initial
    begin
        #1000ms;
        $display("Timeout after %0d result beats", beats_out);
        $display("testbench NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
